### hdl/interpolating_upsampler_dac_feed_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for concurrent checks on the clk/rst_n domain.
// ----------------------------------------------------------------------------
`ifndef INTERPOLATING_UPSAMPLER_DAC_FEED_DEFINES_SVH
`define INTERPOLATING_UPSAMPLER_DAC_FEED_DEFINES_SVH

// same-cycle implication
`define IUD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IUD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/iud_pkg.sv
// ----------------------------------------------------------------------------
// iud_pkg
// Types, constants and helpers shared by the upsampler controller and datapath.
// ----------------------------------------------------------------------------
package iud_pkg;

  // ring store
  localparam int BUFFER_DEPTH = 256;
  localparam int PTR_W        = $clog2(BUFFER_DEPTH);
  localparam int HALF_DEPTH   = BUFFER_DEPTH / 2;

  // interpolation
  localparam int UPSAMPLE_RATIO = 10;
  localparam int PHASE_W        = (UPSAMPLE_RATIO > 1) ? $clog2(UPSAMPLE_RATIO) : 1;

  localparam int CODE_W      = 12;
  localparam int CODE_MAX    = 4095;
  localparam int CENTER_INIT = 2048;

  // acc holds (cur - prev) * phase, signed
  localparam int ACC_MAX = CODE_MAX * (UPSAMPLE_RATIO - 1);
  localparam int ACC_W   = $clog2(ACC_MAX + 1) + 1;
  // offset (multiple of ratio) making acc non-negative so floor division is a plain divide
  localparam int OFF_Q   = (ACC_MAX + UPSAMPLE_RATIO - 1) / UPSAMPLE_RATIO;
  localparam int OFF     = OFF_Q * UPSAMPLE_RATIO;
  localparam int U_W     = $clog2(OFF + ACC_MAX + 2);
  // reciprocal: error term stays below 2^RS over the whole range of u
  localparam int RS      = U_W + $clog2(UPSAMPLE_RATIO) + 1;
  localparam longint RECIP = ((64'd1 << RS) + UPSAMPLE_RATIO - 1) / UPSAMPLE_RATIO;
  localparam int IPROD_W = U_W + RS;
  localparam int VAL_W   = CODE_W + 3;

  // level scaling: lv*4095/150000 = ((lv*273) >> 4) / 625
  localparam int LEVEL_W      = 21;
  localparam int LEVEL_MAX_UV = 150000;
  localparam int LV_W         = 18;
  localparam int LVL_NUM      = 273;
  localparam int LVL_PROD_W   = 26;
  localparam int LVL_SHIFT    = 4;
  localparam int LVL_Y_W      = LVL_PROD_W - LVL_SHIFT;
  localparam int LVL_RS       = 32;
  localparam longint LVL_RECIP = ((64'd1 << LVL_RS) + 624) / 625;
  localparam int LVL_M_W      = 23;
  localparam int LVL_CPROD_W  = LVL_Y_W + LVL_M_W;

  localparam int CNT_W     = 32;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 80;

  typedef enum logic [1:0] {
    FUNC_SAMPLE  = 2'd0,
    FUNC_TICK    = 2'd1,
    FUNC_RESTART = 2'd2
  } func_e_t;

  typedef struct packed {
    logic latch;          // capture accepted request
    logic level_mul;      // clamp level and scale by 273
    logic code_load;      // finish code conversion, shift endpoints
    logic tick_load;      // pop ring head into output register
    logic restart_init;   // reset pointers, endpoints and counters
    logic prefill_write;  // write center code at write pointer
    logic fill_write;     // write interpolated code at write pointer
  } iud_cmd_t;

  typedef struct packed {
    func_e_t func;
    logic    full;
    logic    one_left;
    logic    half_end;
    logic    out_free;
  } iud_sts_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

### hdl/interpolating_upsampler_dac_feed.sv
// Tick with a full ring: accepted in idle, loaded into the output register from exec,
// then one refill write in fill; a tick waits in decode while the output register
// holds an unread result. Model sample: idle, exec, conv, fill; unused func: idle,
// exec, fill. Restart: exec, then a prefill sweep of half the ring and a refill of the
// remaining free slots. First request after reset refills the ring, one slot per cycle.
// Reset (sync, rst_n low): ring empty, endpoints and center_code 2048, counters 0.
// ----------------------------------------------------------------------------
// interpolating_upsampler_dac_feed
// Linear-interpolating upsampler with a ring store feeding a DAC on each tick.
// ----------------------------------------------------------------------------
module interpolating_upsampler_dac_feed (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [iud_pkg::CODE_W-1:0]     cfg_wr_data,   // center_code
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [iud_pkg::IN_DATA_W-1:0]  in_tdata,      // [20:0] ac_level_uv
  input  logic [1:0]                     in_tuser,      // [1:0] func
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [11:0] dac_code, [43:12] underrun_total, [75:44] sent_total
  output logic [iud_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tuser      // [0] code_present
);
  import iud_pkg::*;

  iud_cmd_t cmd;
  iud_sts_t sts;

  iud_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  iud_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

### hdl/iud_ctrl.sv
// ----------------------------------------------------------------------------
// iud_ctrl
// Request sequencer: decode, code conversion, prefill sweep and ring refill.
// ----------------------------------------------------------------------------
module iud_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  iud_pkg::iud_sts_t sts,
  output iud_pkg::iud_cmd_t cmd
);
  import iud_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_EXEC    = 5'b00010,
    S_CONV    = 5'b00100,
    S_PREFILL = 5'b01000,
    S_FILL    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.func)
          FUNC_SAMPLE: begin
            cmd.level_mul = 1'b1;
            state_nxt     = S_CONV;
          end
          FUNC_TICK: begin
            // hold until the output register can take the result
            if (sts.out_free) begin
              cmd.tick_load = 1'b1;
              state_nxt     = S_FILL;
            end
          end
          FUNC_RESTART: begin
            cmd.restart_init = 1'b1;
            state_nxt        = S_PREFILL;
          end
          default: state_nxt = S_FILL;
        endcase
      end
      S_CONV: begin
        cmd.code_load = 1'b1;
        state_nxt     = S_FILL;
      end
      S_PREFILL: begin
        cmd.prefill_write = 1'b1;
        if (sts.half_end) begin
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        if (sts.full) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.fill_write = 1'b1;
          if (sts.one_left) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/iud_datapath.sv
// ----------------------------------------------------------------------------
// iud_datapath
// Ring store, pointers, interpolation endpoints, level scaling and output register.
// ----------------------------------------------------------------------------
`include "interpolating_upsampler_dac_feed_defines.svh"

module iud_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [iud_pkg::CODE_W-1:0]        cfg_wr_data,
  input  logic [iud_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [iud_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tuser,
  input  iud_pkg::iud_cmd_t                 cmd,
  output iud_pkg::iud_sts_t                 sts
);
  import iud_pkg::*;

  logic [CODE_W-1:0] ring [BUFFER_DEPTH];
  logic [CODE_W-1:0] rd_data_r;

  func_e_t                  func_r;
  logic signed [LEVEL_W-1:0] level_r;
  logic [LVL_PROD_W-1:0]    level_prod_r;

  logic [CODE_W-1:0]        center_r, center_nxt;
  logic [CODE_W-1:0]        prev_r, prev_nxt;
  logic [CODE_W-1:0]        cur_r, cur_nxt;
  logic [PHASE_W-1:0]       phase_r, phase_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic [PTR_W-1:0]         rp_r, rp_nxt;
  logic [PTR_W-1:0]         wp_r, wp_nxt;
  logic [CNT_W-1:0]         und_r, und_nxt;
  logic [CNT_W-1:0]         sent_r, sent_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]        out_code_r;
  logic                     out_present_r;
  logic [CNT_W-1:0]         out_und_r;
  logic [CNT_W-1:0]         out_sent_r;

  logic [PTR_W-1:0]         wp_inc, wp_inc2;
  logic                     present;

  // level conversion
  logic [LV_W-1:0]          lv_clamped;
  logic [LVL_CPROD_W-1:0]   code_prod;

  // interpolation
  logic signed [CODE_W:0]   diff;
  logic signed [U_W:0]      u_s;
  logic [IPROD_W-1:0]       iprod;
  logic signed [VAL_W-1:0]  val_s;
  logic [CODE_W-1:0]        interp_val;
  logic                     phase_wrap;

  assign wp_inc  = ptr_inc(wp_r);
  assign wp_inc2 = ptr_inc(wp_inc);
  assign present = (rp_r != wp_r);

  assign sts.func     = func_r;
  assign sts.full     = (wp_inc == rp_r);
  assign sts.one_left = (wp_inc2 == rp_r);
  assign sts.half_end = (wp_r == PTR_W'(HALF_DEPTH - 1));
  assign sts.out_free = !out_valid_r || out_tready;

  always_comb begin
    if (level_r[LEVEL_W-1]) begin
      lv_clamped = '0;
    end else if (level_r > LEVEL_W'(LEVEL_MAX_UV)) begin
      lv_clamped = LV_W'(LEVEL_MAX_UV);
    end else begin
      lv_clamped = level_r[LV_W-1:0];
    end
  end

  // y < 2^22 keeps the reciprocal error under one ulp, so no correction step
  assign code_prod = LVL_CPROD_W'(level_prod_r[LVL_PROD_W-1:LVL_SHIFT])
                   * LVL_CPROD_W'(LVL_RECIP);

  assign diff  = $signed({1'b0, cur_r}) - $signed({1'b0, prev_r});
  assign u_s   = (U_W+1)'(acc_r) + (U_W+1)'(OFF);
  assign iprod = IPROD_W'(u_s[U_W-1:0]) * IPROD_W'(RECIP);
  // floor((cur-prev)*phase/ratio) = floor((acc+OFF)/ratio) - OFF_Q
  assign val_s = $signed({1'b0, iprod[RS +: CODE_W+2]}) - VAL_W'(OFF_Q)
               + $signed({3'b000, prev_r});

  always_comb begin
    if (val_s < 0) begin
      interp_val = '0;
    end else if (val_s > VAL_W'(CODE_MAX)) begin
      interp_val = CODE_W'(CODE_MAX);
    end else begin
      interp_val = val_s[CODE_W-1:0];
    end
  end

  assign phase_wrap = (phase_r == PHASE_W'(UPSAMPLE_RATIO - 1));

  always_comb begin
    center_nxt    = center_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    phase_nxt     = phase_r;
    acc_nxt       = acc_r;
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    und_nxt       = und_r;
    sent_nxt      = sent_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (cfg_wr_en) begin
      center_nxt = cfg_wr_data;
    end
    if (cmd.code_load) begin
      prev_nxt  = cur_r;
      cur_nxt   = code_prod[LVL_RS +: CODE_W];
      phase_nxt = '0;
      acc_nxt   = '0;
    end
    if (cmd.tick_load) begin
      out_valid_nxt = 1'b1;
      if (present) begin
        rp_nxt   = ptr_inc(rp_r);
        sent_nxt = sent_r + CNT_W'(1);
      end else begin
        und_nxt = und_r + CNT_W'(1);
      end
    end
    if (cmd.restart_init) begin
      rp_nxt    = '0;
      wp_nxt    = '0;
      prev_nxt  = center_r;
      cur_nxt   = center_r;
      phase_nxt = '0;
      acc_nxt   = '0;
      und_nxt   = '0;
      sent_nxt  = '0;
    end
    if (cmd.prefill_write) begin
      wp_nxt = wp_inc;
    end
    if (cmd.fill_write) begin
      wp_nxt = wp_inc;
      if (phase_wrap) begin
        phase_nxt = '0;
        acc_nxt   = '0;
        prev_nxt  = cur_r;
      end else begin
        phase_nxt = phase_r + PHASE_W'(1);
        acc_nxt   = acc_r + ACC_W'(diff);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r    <= CODE_W'(CENTER_INIT);
      prev_r      <= CODE_W'(CENTER_INIT);
      cur_r       <= CODE_W'(CENTER_INIT);
      phase_r     <= '0;
      acc_r       <= '0;
      rp_r        <= '0;
      wp_r        <= '0;
      und_r       <= '0;
      sent_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      center_r    <= center_nxt;
      prev_r      <= prev_nxt;
      cur_r       <= cur_nxt;
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      und_r       <= und_nxt;
      sent_r      <= sent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r  <= func_e_t'(in_tuser);
      level_r <= $signed(in_tdata[LEVEL_W-1:0]);
    end
    if (cmd.level_mul) begin
      level_prod_r <= LVL_PROD_W'(lv_clamped) * LVL_PROD_W'(LVL_NUM);
    end
    if (cmd.tick_load) begin
      out_code_r    <= present ? rd_data_r : '0;
      out_present_r <= present;
      out_und_r     <= und_nxt;
      out_sent_r    <= sent_nxt;
    end
  end

  // ring store: one write port, one registered read port at the read pointer
  always_ff @(posedge clk) begin
    if (cmd.prefill_write) begin
      ring[wp_r] <= center_r;
    end else if (cmd.fill_write) begin
      ring[wp_r] <= interp_val;
    end
    rd_data_r <= ring[rp_r];
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_present_r;
  assign out_tdata  = {4'b0000, out_sent_r, out_und_r, out_code_r};

  `IUD_ASSERT_IMP(a_fill_not_full, cmd.fill_write, !sts.full, "refill write into a full ring")
  `IUD_ASSERT_NXT(a_fill_advance, cmd.fill_write, wp_r == $past(wp_inc), "write pointer did not advance")
  `IUD_ASSERT_IMP(a_tick_room, cmd.tick_load, sts.out_free, "result loaded over a pending one")
  `IUD_ASSERT_NXT(a_sent_count, cmd.tick_load && present, out_sent_r == $past(sent_r) + 32'd1, "sent count mismatch")

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the interpolating upsampler DAC feed. Sample, tick,
// restart and no-op requests are streamed in with bursty timing. A local
// ring/interpolator predictor produces the DAC words each tick should return.
// These are compared field by field with the output stream, under random
// back-pressure and under several center-code settings.
// ----------------------------------------------------------------------------
module tb;
  import iud_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;  // unused func code, no action
  localparam int SETTLE_CYCLES  = 2 * BUFFER_DEPTH + 40;
  localparam int STALL_LIMIT    = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int RAND_PER_PHASE = 170;
  localparam int PRESSURE_TICKS = 60;

  typedef struct {
    logic [1:0]         func;
    logic [LEVEL_W-1:0] level;
  } feed_req_t;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic              present;
    logic [CNT_W-1:0]  underruns;
    logic [CNT_W-1:0]  sent;
  } dac_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CODE_W-1:0]     cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  interpolating_upsampler_dac_feed u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  feed_req_t req_queue[$];
  dac_word_t due_words[$];
  int        mismatches = 0;

  // predictor state
  logic [CODE_W-1:0] ring_mdl [BUFFER_DEPTH];
  int                rd_ptr = 0;
  int                wr_ptr = 0;
  int                prev_code = CENTER_INIT;
  int                cur_code = CENTER_INIT;
  int                phase = 0;
  logic [CNT_W-1:0]  underrun_cnt = '0;
  logic [CNT_W-1:0]  sent_cnt = '0;
  int                center = CENTER_INIT;

  function automatic int level_code(logic signed [LEVEL_W-1:0] lvl);
    longint v;
    v = lvl;
    if (v < 0) v = 0;
    if (v > LEVEL_MAX_UV) v = LEVEL_MAX_UV;
    return int'((v * CODE_MAX) / LEVEL_MAX_UV);
  endfunction

  // prev + floor((cur - prev) * phase / ratio), clamped
  function automatic int interp_code();
    int prod;
    int q;
    int val;
    prod = (cur_code - prev_code) * phase;
    if (prod >= 0) q = prod / UPSAMPLE_RATIO;
    else q = -((-prod + UPSAMPLE_RATIO - 1) / UPSAMPLE_RATIO);
    val = prev_code + q;
    if (val < 0) val = 0;
    if (val > CODE_MAX) val = CODE_MAX;
    return val;
  endfunction

  function automatic void refill_ring();
    int free_slots;
    free_slots = (rd_ptr + BUFFER_DEPTH - wr_ptr - 1) % BUFFER_DEPTH;
    while (free_slots > 0) begin
      ring_mdl[wr_ptr] = CODE_W'(interp_code());
      wr_ptr = (wr_ptr + 1) % BUFFER_DEPTH;
      free_slots--;
      phase++;
      if (phase >= UPSAMPLE_RATIO) begin
        phase = 0;
        prev_code = cur_code;
      end
    end
  endfunction

  function automatic void predict_feed(logic [1:0] func, logic [LEVEL_W-1:0] level);
    dac_word_t w;
    case (func)
      FUNC_SAMPLE: begin
        prev_code = cur_code;
        cur_code = level_code(level);
        phase = 0;
      end
      FUNC_TICK: begin
        w.code = '0;
        w.present = 1'b0;
        if (rd_ptr != wr_ptr) begin
          w.code = ring_mdl[rd_ptr];
          w.present = 1'b1;
          rd_ptr = (rd_ptr + 1) % BUFFER_DEPTH;
          sent_cnt = sent_cnt + 1'b1;
        end else begin
          underrun_cnt = underrun_cnt + 1'b1;
        end
        w.underruns = underrun_cnt;
        w.sent = sent_cnt;
        due_words.push_back(w);
      end
      FUNC_RESTART: begin
        for (int i = 0; i < HALF_DEPTH; i++) ring_mdl[i] = CODE_W'(center);
        rd_ptr = 0;
        wr_ptr = HALF_DEPTH % BUFFER_DEPTH;
        prev_code = center;
        cur_code = center;
        phase = 0;
        underrun_cnt = '0;
        sent_cnt = '0;
      end
      default: ;
    endcase
    refill_ring();
  endfunction

  task automatic report_mismatch(string what, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
    if (mismatches < 100)
      $display("tb: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // ---------------- input driver ----------------
  logic in_taken = 1'b0;
  int   burst_left = 1;
  int   gap_left = 0;

  always @(negedge clk) begin
    feed_req_t r;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (req_queue.size() > 0) begin
        r = req_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= r.func;
        in_tdata <= {{(IN_DATA_W - LEVEL_W){1'b0}}, r.level};
        burst_left--;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(40, 150);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = $urandom_range(0, 7);
          end
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- result receiver ----------------
  logic hold_req = 1'b0;
  int   hold_left = 0;
  int   pat_left = 0;
  int   pat_mode = 0;

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (pat_left <= 0) begin
        pat_mode = $urandom_range(0, 3);
        pat_left = $urandom_range(10, 80);
      end
      pat_left--;
      case (pat_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        2: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------- predict and check ----------------
  always @(posedge clk) begin
    dac_word_t w;
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken) predict_feed(in_tuser, in_tdata[LEVEL_W-1:0]);
    if (rst_n && out_tvalid && out_tready) begin
      if (due_words.size() == 0) begin
        report_mismatch("unexpected result, dac_code", out_tdata[11:0], '0);
      end else begin
        w = due_words.pop_front();
        if (out_tdata[11:0] !== w.code) report_mismatch("dac_code", out_tdata[11:0], w.code);
        if (out_tuser !== w.present)
          report_mismatch("code_present", out_tuser, w.present);
        if (out_tdata[43:12] !== w.underruns)
          report_mismatch("underrun_total", out_tdata[43:12], w.underruns);
        if (out_tdata[75:44] !== w.sent) report_mismatch("sent_total", out_tdata[75:44], w.sent);
      end
    end
  end

  // ---------------- watchdog ----------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic feed_req_t make_req(logic [1:0] func, int level);
    feed_req_t r;
    r.func = func;
    r.level = LEVEL_W'(level);
    return r;
  endfunction

  function automatic int rand_level();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5) return $urandom_range(0, LEVEL_MAX_UV);
    if (sel == 6) begin
      case ($urandom_range(0, 3))
        0: return 0;
        1: return LEVEL_MAX_UV;
        2: return -1;
        default: return LEVEL_MAX_UV + 1;
      endcase
    end
    return int'($urandom_range(0, 2000000)) - 1000000;
  endfunction

  task automatic push_random(int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) req_queue.push_back(make_req(FUNC_TICK, rand_level()));
      else if (sel < 92) req_queue.push_back(make_req(FUNC_SAMPLE, rand_level()));
      else if (sel < 96) req_queue.push_back(make_req(FUNC_NONE, rand_level()));
      else req_queue.push_back(make_req(FUNC_RESTART, rand_level()));
    end
  endtask

  // drain everything, then let a restart or refill sweep finish
  task automatic wait_idle();
    while (req_queue.size() != 0 || in_tvalid || due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_center(logic [CODE_W-1:0] code);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= code;
    center = code;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: underrun after reset, level extremes, no-op, restart
    req_queue.push_back(make_req(FUNC_TICK, 0));
    req_queue.push_back(make_req(FUNC_TICK, -1));
    req_queue.push_back(make_req(FUNC_SAMPLE, 0));
    req_queue.push_back(make_req(FUNC_SAMPLE, LEVEL_MAX_UV));
    req_queue.push_back(make_req(FUNC_SAMPLE, LEVEL_MAX_UV + 1));
    req_queue.push_back(make_req(FUNC_SAMPLE, 1000000));
    req_queue.push_back(make_req(FUNC_SAMPLE, -1));
    req_queue.push_back(make_req(FUNC_SAMPLE, -1000000));
    req_queue.push_back(make_req(FUNC_SAMPLE, LEVEL_MAX_UV - 1));
    req_queue.push_back(make_req(FUNC_SAMPLE, 37));
    req_queue.push_back(make_req(FUNC_NONE, 12345));
    repeat (3) req_queue.push_back(make_req(FUNC_TICK, 0));
    req_queue.push_back(make_req(FUNC_RESTART, 0));
    repeat (2) req_queue.push_back(make_req(FUNC_TICK, 0));
    req_queue.push_back(make_req(FUNC_SAMPLE, 75000));
    req_queue.push_back(make_req(FUNC_TICK, 0));
    req_queue.push_back(make_req(FUNC_NONE, -1000000));
    req_queue.push_back(make_req(FUNC_TICK, 1000000));
    push_random(RAND_PER_PHASE);
    wait_idle();

    write_center('0);
    req_queue.push_back(make_req(FUNC_RESTART, 0));
    push_random(RAND_PER_PHASE);
    wait_idle();

    // long receiver hold-off while ticks keep coming
    write_center(CODE_W'(CODE_MAX));
    req_queue.push_back(make_req(FUNC_RESTART, 0));
    hold_req = 1'b1;
    repeat (PRESSURE_TICKS) req_queue.push_back(make_req(FUNC_TICK, rand_level()));
    push_random(RAND_PER_PHASE);
    wait_idle();

    write_center(CODE_W'($urandom_range(0, CODE_MAX)));
    req_queue.push_back(make_req(FUNC_RESTART, 0));
    push_random(RAND_PER_PHASE);
    wait_idle();

    // new center without a restart: only later restarts pick it up
    write_center(CODE_W'($urandom_range(0, CODE_MAX)));
    push_random(RAND_PER_PHASE);
    wait_idle();

    if (mismatches == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
